/* design/bsc_pkg.sv */
// ----------------------------------------------------------------------------
// bsc_pkg
// Shared constants, codes and row types of the Banker's safety checker.
// ----------------------------------------------------------------------------
package bsc_pkg;

  localparam int MAX_PROCESSES = 8;
  localparam int MAX_RESOURCES = 4;
  localparam int COUNT_BITS    = 8;

  localparam int WORK_W     = COUNT_BITS + 3;
  localparam int PROC_W     = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
  localparam int RES_W      = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
  localparam int PROC_CNT_W = $clog2(MAX_PROCESSES + 1);
  localparam int RES_CNT_W  = $clog2(MAX_RESOURCES + 1);
  localparam int ROW_W      = MAX_RESOURCES * COUNT_BITS;

  localparam logic [WORK_W-1:0] WORK_MAX = {WORK_W{1'b1}};

  // input modes
  localparam logic [2:0] MODE_WR_ALLOC = 3'd0;
  localparam logic [2:0] MODE_WR_MAX   = 3'd1;
  localparam logic [2:0] MODE_WR_AVAIL = 3'd2;
  localparam logic [2:0] MODE_STAGE    = 3'd3;
  localparam logic [2:0] MODE_SUBMIT   = 3'd4;
  localparam logic [2:0] MODE_CHECK    = 3'd5;

  // result status
  localparam logic [1:0] ST_SAFE    = 2'd0;
  localparam logic [1:0] ST_UNSAFE  = 2'd1;
  localparam logic [1:0] ST_REFUSED = 2'd2;

  // config register indexes
  localparam logic CFG_NUM_PROC = 1'b0;
  localparam logic CFG_NUM_RES  = 1'b1;

  typedef logic [MAX_RESOURCES-1:0][COUNT_BITS-1:0] row_t;
  typedef logic [MAX_RESOURCES-1:0][WORK_W-1:0]     work_t;

  typedef struct packed {
    logic fits;    // need fits work vector
    logic req_ok;  // request within available and need
  } eval_t;

endpackage

/* design/bsc_ram.sv */
// ----------------------------------------------------------------------------
// bsc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bsc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* design/bsc_row_eval.sv */
// ----------------------------------------------------------------------------
// bsc_row_eval
// Per-process row evaluation: need vs work, work update, request check.
// ----------------------------------------------------------------------------
module bsc_row_eval (
  input  bsc_pkg::row_t                      alloc,
  input  bsc_pkg::row_t                      max_claim,
  input  bsc_pkg::work_t                     work,
  input  bsc_pkg::row_t                      req,
  input  bsc_pkg::row_t                      avail,
  input  logic [bsc_pkg::MAX_RESOURCES-1:0]  res_mask,
  output bsc_pkg::eval_t                     result,
  output bsc_pkg::work_t                     work_sum,
  output bsc_pkg::row_t                      alloc_grant,
  output bsc_pkg::row_t                      avail_grant
);

  bsc_pkg::row_t                     need;
  logic [bsc_pkg::MAX_RESOURCES-1:0] fit_bits;
  logic [bsc_pkg::MAX_RESOURCES-1:0] req_bits;
  logic [bsc_pkg::WORK_W:0]          sum [bsc_pkg::MAX_RESOURCES];

  always_comb begin
    for (int i = 0; i < bsc_pkg::MAX_RESOURCES; i++) begin
      need[i] = (max_claim[i] > alloc[i]) ? (max_claim[i] - alloc[i]) : '0;
      fit_bits[i] = !res_mask[i] ||
                    ({{(bsc_pkg::WORK_W-bsc_pkg::COUNT_BITS){1'b0}}, need[i]} <= work[i]);
      req_bits[i] = !res_mask[i] || ((req[i] <= avail[i]) && (req[i] <= need[i]));
      sum[i] = {1'b0, work[i]} +
               {{(bsc_pkg::WORK_W+1-bsc_pkg::COUNT_BITS){1'b0}}, alloc[i]};
      if (!res_mask[i]) begin
        work_sum[i] = work[i];
      end else if (sum[i][bsc_pkg::WORK_W]) begin
        work_sum[i] = bsc_pkg::WORK_MAX;
      end else begin
        work_sum[i] = sum[i][bsc_pkg::WORK_W-1:0];
      end
      alloc_grant[i] = res_mask[i] ? (alloc[i] + req[i]) : alloc[i];
      avail_grant[i] = res_mask[i] ? (avail[i] - req[i]) : avail[i];
    end
    result.fits   = &fit_bits;
    result.req_ok = &req_bits;
  end

endmodule

/* design/bankers_safety_checker.sv */
// ----------------------------------------------------------------------------
// bankers_safety_checker
// Banker's algorithm deadlock-avoidance checker over row-wide table RAMs.
// ----------------------------------------------------------------------------
// Table writes (alloc, max) are a row read-modify-write. Available and staged
//   writes go straight to registers. One item at a time.
// Safety check: per process visited a RAM read, then evaluate; up to np passes
//   of np processes, plus setup/finish, then 1 result beat per cycle while
//   m_tready is high. Submit adds a request-check state (S_SUB) first.
// Reset (sync, rst high): available/staged zero, registers at maximum; table
//   RAMs cleared by a sweep of all MAX_PROCESSES rows before items are taken.
module bankers_safety_checker (
  input  logic        clk,
  input  logic        rst,
  // input beats
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // process_index[2:0], resource_index[4:3], value[12:5]
  input  logic [2:0]  s_tuser,   // mode[2:0]
  // result beats
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // status[1:0], process_id[4:2]
  output logic        m_tlast,
  // config writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [3:0]  cfg_data
);

  localparam int PW = bsc_pkg::PROC_W;
  localparam int CW = bsc_pkg::PROC_CNT_W + 3;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_WR    = 4'd2;
  localparam logic [3:0] S_SUB   = 4'd3;
  localparam logic [3:0] S_INIT  = 4'd4;
  localparam logic [3:0] S_RD    = 4'd5;
  localparam logic [3:0] S_EV    = 4'd6;
  localparam logic [3:0] S_FIN   = 4'd7;
  localparam logic [3:0] S_EMIT  = 4'd8;

  logic [3:0] state;

  // config registers and in-use counts
  logic [3:0] num_proc;
  logic [2:0] num_res;
  logic [bsc_pkg::PROC_CNT_W-1:0] np;
  logic [bsc_pkg::RES_CNT_W-1:0]  nr;
  logic [bsc_pkg::MAX_RESOURCES-1:0] res_mask;

  // vectors held in flops
  bsc_pkg::row_t  avail, staged, old_avail, old_alloc;
  bsc_pkg::work_t work;
  logic [bsc_pkg::MAX_PROCESSES-1:0] finished;
  logic [PW-1:0] order [bsc_pkg::MAX_PROCESSES];

  // latched item
  logic [2:0] mode_q;
  logic [PW-1:0] p_q;
  logic [bsc_pkg::RES_W-1:0] r_q;
  logic [bsc_pkg::COUNT_BITS-1:0] v_q;

  // sweep control
  logic [PW-1:0] sp;
  logic [bsc_pkg::PROC_CNT_W-1:0] done_cnt, k;
  logic progress, rollback;
  logic [1:0] emit_kind;

  // output register
  logic       out_valid;
  logic [1:0] out_status;
  logic [2:0] out_pid;
  logic       out_last;

  // RAM ports
  logic ram_a_we, ram_m_we;
  logic [PW-1:0] ram_rd_addr, ram_wr_addr;
  bsc_pkg::row_t ram_a_wd, ram_m_wd, alloc_rd, max_rd;

  // row evaluation
  bsc_pkg::eval_t ev;
  bsc_pkg::work_t work_sum;
  bsc_pkg::row_t  alloc_grant, avail_grant;

  // input fields
  logic [2:0] in_mode;
  logic [2:0] in_p;
  logic [1:0] in_r;
  logic [7:0] in_v;
  logic       in_acc;

  assign in_mode = s_tuser;
  assign in_p    = s_tdata[2:0];
  assign in_r    = s_tdata[4:3];
  assign in_v    = s_tdata[12:5];
  assign s_tready = (state == S_IDLE);
  assign in_acc  = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  assign m_tvalid = out_valid;
  assign m_tdata  = {3'b000, out_pid, out_status};
  assign m_tlast  = out_last;

  // zero -> 1, above max -> max
  always_comb begin
    if (num_proc == 4'd0) begin
      np = bsc_pkg::PROC_CNT_W'(1);
    end else if (int'(num_proc) > bsc_pkg::MAX_PROCESSES) begin
      np = bsc_pkg::PROC_CNT_W'(bsc_pkg::MAX_PROCESSES);
    end else begin
      np = bsc_pkg::PROC_CNT_W'(num_proc);
    end
    if (num_res == 3'd0) begin
      nr = bsc_pkg::RES_CNT_W'(1);
    end else if (int'(num_res) > bsc_pkg::MAX_RESOURCES) begin
      nr = bsc_pkg::RES_CNT_W'(bsc_pkg::MAX_RESOURCES);
    end else begin
      nr = bsc_pkg::RES_CNT_W'(num_res);
    end
    for (int i = 0; i < bsc_pkg::MAX_RESOURCES; i++) begin
      res_mask[i] = (i < int'(nr));
    end
  end

  bsc_ram #(.WIDTH(bsc_pkg::ROW_W), .DEPTH(bsc_pkg::MAX_PROCESSES)) u_alloc_ram (
    .clk     (clk),
    .wr_en   (ram_a_we),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_a_wd),
    .rd_addr (ram_rd_addr),
    .rd_data (alloc_rd)
  );

  bsc_ram #(.WIDTH(bsc_pkg::ROW_W), .DEPTH(bsc_pkg::MAX_PROCESSES)) u_max_ram (
    .clk     (clk),
    .wr_en   (ram_m_we),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_m_wd),
    .rd_addr (ram_rd_addr),
    .rd_data (max_rd)
  );

  bsc_row_eval u_eval (
    .alloc       (alloc_rd),
    .max_claim   (max_rd),
    .work        (work),
    .req         (staged),
    .avail       (avail),
    .res_mask    (res_mask),
    .result      (ev),
    .work_sum    (work_sum),
    .alloc_grant (alloc_grant),
    .avail_grant (avail_grant)
  );

  logic safe;
  logic emit_go;
  logic sweep_take;
  logic [bsc_pkg::PROC_CNT_W-1:0] done_next;

  assign safe       = (done_cnt == np);
  assign emit_go    = (state == S_EMIT) && (!out_valid || m_tready);
  assign sweep_take = !finished[sp] && ev.fits;
  assign done_next  = sweep_take ? (done_cnt + 1'b1) : done_cnt;

  // RAM port muxing
  always_comb begin
    ram_rd_addr = (state == S_RD) ? sp : PW'(in_p);
    ram_wr_addr = (state == S_CLEAR) ? sp : p_q;
    ram_a_we    = 1'b0;
    ram_m_we    = 1'b0;
    ram_a_wd    = alloc_rd;
    ram_m_wd    = max_rd;
    unique case (state)
      S_CLEAR: begin
        ram_a_we = 1'b1;
        ram_m_we = 1'b1;
        ram_a_wd = '0;
        ram_m_wd = '0;
      end
      S_WR: begin
        // element merge into the row just read
        ram_a_wd[r_q] = v_q;
        ram_m_wd[r_q] = v_q;
        ram_a_we = (mode_q == bsc_pkg::MODE_WR_ALLOC);
        ram_m_we = (mode_q == bsc_pkg::MODE_WR_MAX);
      end
      S_SUB: begin
        ram_a_we = ev.req_ok;
        ram_a_wd = alloc_grant;
      end
      S_FIN: begin
        // undo a tentative grant that left the state unsafe
        ram_a_we = !safe && rollback;
        ram_a_wd = old_alloc;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      num_proc  <= 4'(bsc_pkg::MAX_PROCESSES);
      num_res   <= 3'(bsc_pkg::MAX_RESOURCES);
      avail     <= '0;
      staged    <= '0;
      finished  <= '0;
      work      <= '0;
      sp        <= '0;
      done_cnt  <= '0;
      k         <= '0;
      progress  <= 1'b0;
      rollback  <= 1'b0;
      emit_kind <= bsc_pkg::ST_SAFE;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == bsc_pkg::CFG_NUM_PROC) begin
          num_proc <= cfg_data;
        end else begin
          num_res <= cfg_data[2:0];
        end
      end

      if (out_valid && m_tready && !emit_go) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_CLEAR: begin
          sp <= sp + 1'b1;
          if (int'(sp) == bsc_pkg::MAX_PROCESSES - 1) begin
            sp    <= '0;
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            mode_q <= in_mode;
            p_q    <= PW'(in_p);
            r_q    <= bsc_pkg::RES_W'(in_r);
            v_q    <= bsc_pkg::COUNT_BITS'(in_v);
            case (in_mode)
              bsc_pkg::MODE_WR_ALLOC, bsc_pkg::MODE_WR_MAX: begin
                if ((int'(in_p) < bsc_pkg::MAX_PROCESSES) &&
                    (int'(in_r) < bsc_pkg::MAX_RESOURCES)) begin
                  state <= S_WR;
                end
              end
              bsc_pkg::MODE_WR_AVAIL: begin
                if (int'(in_r) < bsc_pkg::MAX_RESOURCES) begin
                  avail[bsc_pkg::RES_W'(in_r)] <= bsc_pkg::COUNT_BITS'(in_v);
                end
              end
              bsc_pkg::MODE_STAGE: begin
                if (int'(in_r) < bsc_pkg::MAX_RESOURCES) begin
                  staged[bsc_pkg::RES_W'(in_r)] <= bsc_pkg::COUNT_BITS'(in_v);
                end
              end
              bsc_pkg::MODE_SUBMIT: begin
                if (CW'(in_p) >= CW'(np)) begin
                  emit_kind <= bsc_pkg::ST_REFUSED;
                  state     <= S_EMIT;
                end else begin
                  state <= S_SUB;
                end
              end
              bsc_pkg::MODE_CHECK: begin
                rollback <= 1'b0;
                state    <= S_INIT;
              end
              default: begin
              end
            endcase
          end
        end
        S_WR: begin
          state <= S_IDLE;
        end
        S_SUB: begin
          if (ev.req_ok) begin
            old_alloc <= alloc_rd;
            old_avail <= avail;
            avail     <= avail_grant;
            rollback  <= 1'b1;
            state     <= S_INIT;
          end else begin
            emit_kind <= bsc_pkg::ST_REFUSED;
            state     <= S_EMIT;
          end
        end
        S_INIT: begin
          for (int i = 0; i < bsc_pkg::MAX_RESOURCES; i++) begin
            work[i] <= bsc_pkg::WORK_W'(avail[i]);
          end
          finished <= '0;
          done_cnt <= '0;
          progress <= 1'b0;
          sp       <= '0;
          state    <= S_RD;
        end
        S_RD: begin
          state <= S_EV;
        end
        S_EV: begin
          if (sweep_take) begin
            work            <= work_sum;
            finished[sp]    <= 1'b1;
            order[done_cnt[PW-1:0]] <= sp;
            done_cnt        <= done_next;
          end
          state <= S_RD;
          if (CW'(sp) == CW'(np) - 1'b1) begin
            // end of pass: stop when all done or nothing finished this pass
            if ((done_next == np) || !(progress || sweep_take)) begin
              state <= S_FIN;
            end
            sp       <= '0;
            progress <= 1'b0;
          end else begin
            sp <= sp + 1'b1;
            if (sweep_take) begin
              progress <= 1'b1;
            end
          end
        end
        S_FIN: begin
          if (!safe && rollback) begin
            avail <= old_avail;
          end
          emit_kind <= safe ? bsc_pkg::ST_SAFE : bsc_pkg::ST_UNSAFE;
          k         <= '0;
          state     <= S_EMIT;
        end
        S_EMIT: begin
          if (emit_go) begin
            out_valid <= 1'b1;
            if (emit_kind == bsc_pkg::ST_SAFE) begin
              out_status <= bsc_pkg::ST_SAFE;
              out_pid    <= 3'(order[k[PW-1:0]]);
              out_last   <= (k == np - 1'b1);
              k          <= k + 1'b1;
              if (k == np - 1'b1) begin
                state <= S_IDLE;
              end
            end else begin
              out_status <= emit_kind;
              out_pid    <= 3'd0;
              out_last   <= 1'b1;
              state      <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
